// ===== rtl/core/gmmpc_pkg.sv =====
package gmmpc_pkg;

   // pixel channel and offset widths
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned PIX_W    = 16;
   localparam int unsigned DIFF_W   = PIX_W + 1;
   localparam int unsigned PROD_W   = 2 * DIFF_W;
   localparam int unsigned COEF_W   = 21;
   localparam int unsigned TERM_W   = COEF_W + PROD_W;
   localparam int unsigned QSUM_W   = TERM_W + 2;
   localparam int unsigned BIAS_W   = 32;
   localparam int unsigned FRAC_SH  = 29;
   localparam int unsigned SCORE_W  = 63;
   localparam int unsigned SDIFF_W  = SCORE_W + 1;
   localparam int unsigned OUT_W    = 32;
   localparam int unsigned MASK_W   = 8;

   // configuration port
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned MEANS_W    = 48;
   localparam int unsigned PACK_W     = 63;

   localparam int unsigned NUM_COMP  = 2;
   localparam int unsigned NUM_CHAN  = 3;
   localparam int unsigned NUM_TERM  = 6;
   localparam int unsigned NUM_STAGE = 7;

   localparam logic [MASK_W-1:0] MASK_SET = 8'd255;
   localparam logic [MASK_W-1:0] MASK_CLR = 8'd0;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FIRST_MEANS  = 3'd0,
      REG_FIRST_DIAG   = 3'd1,
      REG_FIRST_CROSS  = 3'd2,
      REG_FIRST_BIAS   = 3'd3,
      REG_SECOND_MEANS = 3'd4,
      REG_SECOND_DIAG  = 3'd5,
      REG_SECOND_CROSS = 3'd6,
      REG_SECOND_BIAS  = 3'd7
   } reg_idx_type;

endpackage

// ===== rtl/core/gmm_pixel_classifier.sv =====
// Two-component full-covariance Gaussian mixture classifier, one RGB pixel
// per word.
// Request channel (req_valid/req_ready): red, green, blue bytes, the target
// component and a last-pixel flag. Response channel (rsp_valid/rsp_ready):
// mask (255 when the target component scores strictly higher, else 0), the
// winning component, first minus second score in Q23.8 (floored, saturated)
// and the frame-end flag copied from the request.
// Model parameters sit in eight CSRs on the APB-style port at byte address
// 8*index, 64-bit data; write them only while no pixel is in flight.
// Pipeline of seven register stages: offsets, offset products, coefficient
// products, partial sums, scores, score difference, output register. A
// word passes through them in order to rsp_valid; one word per cycle is
// taken and delivered while rsp_ready is high, the rate being set by the
// single pass through the stages with each multiplier used once per pixel.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up and a stalled receiver fills the
// pipeline before req_ready falls; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and clears all CSRs.
module gmm_pixel_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [gmmpc_pkg::CHAN_W-1:0]         req_red,
   input  logic [gmmpc_pkg::CHAN_W-1:0]         req_green,
   input  logic [gmmpc_pkg::CHAN_W-1:0]         req_blue,
   input  logic                                 req_target_component,
   input  logic                                 req_last_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gmmpc_pkg::MASK_W-1:0]         rsp_mask_value,
   output logic                                 rsp_winning_component,
   output logic signed [gmmpc_pkg::OUT_W-1:0]   rsp_score_difference,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gmmpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gmmpc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gmmpc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned NS = gmmpc_pkg::NUM_STAGE;
   localparam int unsigned NC = gmmpc_pkg::NUM_COMP;
   localparam int unsigned NH = gmmpc_pkg::NUM_CHAN;
   localparam int unsigned NT = gmmpc_pkg::NUM_TERM;
   localparam int unsigned CW = gmmpc_pkg::COEF_W;

   // ---------------- CSRs ----------------
   logic [gmmpc_pkg::MEANS_W-1:0] means_ff [NC];
   logic [gmmpc_pkg::PACK_W-1:0]  diag_ff  [NC];
   logic [gmmpc_pkg::PACK_W-1:0]  cross_ff [NC];
   logic [gmmpc_pkg::BIAS_W-1:0]  bias_ff  [NC];

   logic                          csr_wr;
   gmmpc_pkg::reg_idx_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = gmmpc_pkg::reg_idx_type'(csr_paddr[gmmpc_pkg::CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            means_ff[c] <= '0;
            diag_ff[c]  <= '0;
            cross_ff[c] <= '0;
            bias_ff[c]  <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            gmmpc_pkg::REG_FIRST_MEANS:  means_ff[0] <= csr_pwdata[gmmpc_pkg::MEANS_W-1:0];
            gmmpc_pkg::REG_FIRST_DIAG:   diag_ff[0]  <= csr_pwdata[gmmpc_pkg::PACK_W-1:0];
            gmmpc_pkg::REG_FIRST_CROSS:  cross_ff[0] <= csr_pwdata[gmmpc_pkg::PACK_W-1:0];
            gmmpc_pkg::REG_FIRST_BIAS:   bias_ff[0]  <= csr_pwdata[gmmpc_pkg::BIAS_W-1:0];
            gmmpc_pkg::REG_SECOND_MEANS: means_ff[1] <= csr_pwdata[gmmpc_pkg::MEANS_W-1:0];
            gmmpc_pkg::REG_SECOND_DIAG:  diag_ff[1]  <= csr_pwdata[gmmpc_pkg::PACK_W-1:0];
            gmmpc_pkg::REG_SECOND_CROSS: cross_ff[1] <= csr_pwdata[gmmpc_pkg::PACK_W-1:0];
            gmmpc_pkg::REG_SECOND_BIAS:  bias_ff[1]  <= csr_pwdata[gmmpc_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         gmmpc_pkg::REG_FIRST_MEANS:  csr_prdata = 64'(means_ff[0]);
         gmmpc_pkg::REG_FIRST_DIAG:   csr_prdata = 64'(diag_ff[0]);
         gmmpc_pkg::REG_FIRST_CROSS:  csr_prdata = 64'(cross_ff[0]);
         gmmpc_pkg::REG_FIRST_BIAS:   csr_prdata = 64'(bias_ff[0]);
         gmmpc_pkg::REG_SECOND_MEANS: csr_prdata = 64'(means_ff[1]);
         gmmpc_pkg::REG_SECOND_DIAG:  csr_prdata = 64'(diag_ff[1]);
         gmmpc_pkg::REG_SECOND_CROSS: csr_prdata = 64'(cross_ff[1]);
         gmmpc_pkg::REG_SECOND_BIAS:  csr_prdata = 64'(bias_ff[1]);
         default: csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;
   logic [NS-1:0] tgt_ff;
   logic [NS-1:0] lst_ff;

   always_comb begin
      en[NS-1] = ~vld_ff[NS-1] | rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = ~vld_ff[k] | en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tgt_ff[0] <= req_target_component;
         lst_ff[0] <= req_last_pixel;
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            tgt_ff[k] <= tgt_ff[k-1];
            lst_ff[k] <= lst_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: offsets from the means ----------------
   logic signed [gmmpc_pkg::DIFF_W-1:0] d_ff [NC][NH];
   logic signed [gmmpc_pkg::DIFF_W-1:0] d_in [NC][NH];
   logic [gmmpc_pkg::CHAN_W-1:0]        chan [NH];

   assign chan[0] = req_red;
   assign chan[1] = req_green;
   assign chan[2] = req_blue;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         for (int h = 0; h < NH; h++) begin
            // byte*257 is the byte repeated in both halves
            d_in[c][h] = $signed({1'b0, chan[h], chan[h]})
                       - $signed({1'b0, means_ff[c][16*h +: gmmpc_pkg::PIX_W]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) d_ff <= d_in;
   end

   // ---------------- stage 2: offset products ----------------
   // term order: rr, gg, bb, rg, rb, gb
   logic signed [gmmpc_pkg::PROD_W-1:0] p_ff [NC][NT];
   logic signed [gmmpc_pkg::PROD_W-1:0] p_in [NC][NT];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         p_in[c][0] = d_ff[c][0] * d_ff[c][0];
         p_in[c][1] = d_ff[c][1] * d_ff[c][1];
         p_in[c][2] = d_ff[c][2] * d_ff[c][2];
         p_in[c][3] = d_ff[c][0] * d_ff[c][1];
         p_in[c][4] = d_ff[c][0] * d_ff[c][2];
         p_in[c][5] = d_ff[c][1] * d_ff[c][2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) p_ff <= p_in;
   end

   // ---------------- stage 3: times inverse covariance ----------------
   logic signed [gmmpc_pkg::TERM_W-1:0] t_ff [NC][NT];
   logic signed [gmmpc_pkg::TERM_W-1:0] t_in [NC][NT];
   logic signed [CW-1:0]                coef [NC][NT];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         for (int h = 0; h < NH; h++) begin
            coef[c][h]    = $signed(diag_ff[c][CW*h +: CW]);
            coef[c][h+NH] = $signed(cross_ff[c][CW*h +: CW]);
         end
         for (int j = 0; j < NT; j++) begin
            t_in[c][j] = coef[c][j] * p_ff[c][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) t_ff <= t_in;
   end

   // ---------------- stage 4: diagonal and cross sums ----------------
   logic signed [gmmpc_pkg::QSUM_W-1:0] qd_ff [NC];
   logic signed [gmmpc_pkg::QSUM_W-1:0] qc_ff [NC];
   logic signed [gmmpc_pkg::QSUM_W-1:0] qd_in [NC];
   logic signed [gmmpc_pkg::QSUM_W-1:0] qc_in [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         qd_in[c] = gmmpc_pkg::QSUM_W'(t_ff[c][0]) + gmmpc_pkg::QSUM_W'(t_ff[c][1])
                  + gmmpc_pkg::QSUM_W'(t_ff[c][2]);
         qc_in[c] = gmmpc_pkg::QSUM_W'(t_ff[c][3]) + gmmpc_pkg::QSUM_W'(t_ff[c][4])
                  + gmmpc_pkg::QSUM_W'(t_ff[c][5]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         qd_ff <= qd_in;
         qc_ff <= qc_in;
      end
   end

   // ---------------- stage 5: scores, exact at 2^-37 ----------------
   logic signed [gmmpc_pkg::SCORE_W-1:0] sc_ff [NC];
   logic signed [gmmpc_pkg::SCORE_W-1:0] sc_in [NC];
   logic signed [gmmpc_pkg::SCORE_W-1:0] bias_ext [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         bias_ext[c] = gmmpc_pkg::SCORE_W'($signed(bias_ff[c]));
         sc_in[c] = (bias_ext[c] <<< gmmpc_pkg::FRAC_SH)
                  - gmmpc_pkg::SCORE_W'(qd_ff[c])
                  - (gmmpc_pkg::SCORE_W'(qc_ff[c]) <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) sc_ff <= sc_in;
   end

   // ---------------- stage 6: score difference ----------------
   logic signed [gmmpc_pkg::SDIFF_W-1:0] sd_ff;
   logic signed [gmmpc_pkg::SDIFF_W-1:0] sd_in;

   assign sd_in = gmmpc_pkg::SDIFF_W'(sc_ff[0]) - gmmpc_pkg::SDIFF_W'(sc_ff[1]);

   always_ff @(posedge clock) begin
      if (en[5]) sd_ff <= sd_in;
   end

   // ---------------- stage 7: output register ----------------
   localparam int unsigned SH_W = gmmpc_pkg::SDIFF_W - gmmpc_pkg::FRAC_SH;

   logic signed [SH_W-1:0]              sh;
   logic                                second_wins;
   logic                                first_wins;
   logic                                tgt_wins;
   logic [gmmpc_pkg::MASK_W-1:0]        mask_ff,  mask_in;
   logic                                win_ff,   win_in;
   logic signed [gmmpc_pkg::OUT_W-1:0]  sdiff_ff, sdiff_in;

   always_comb begin
      // dropping the fraction bits floors toward minus infinity
      sh          = sd_ff[gmmpc_pkg::SDIFF_W-1:gmmpc_pkg::FRAC_SH];
      second_wins = sd_ff < 0;
      first_wins  = sd_ff > 0;
      tgt_wins    = tgt_ff[5] ? second_wins : first_wins;
      mask_in     = tgt_wins ? gmmpc_pkg::MASK_SET : gmmpc_pkg::MASK_CLR;
      win_in      = second_wins;
      if (sh[SH_W-1:gmmpc_pkg::OUT_W-1] == '0 || sh[SH_W-1:gmmpc_pkg::OUT_W-1] == '1) begin
         sdiff_in = sh[gmmpc_pkg::OUT_W-1:0];
      end else if (sh[SH_W-1]) begin
         sdiff_in = {1'b1, {(gmmpc_pkg::OUT_W-1){1'b0}}};
      end else begin
         sdiff_in = {1'b0, {(gmmpc_pkg::OUT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         mask_ff  <= mask_in;
         win_ff   <= win_in;
         sdiff_ff <= sdiff_in;
      end
   end

   assign rsp_valid             = vld_ff[NS-1];
   assign rsp_mask_value        = mask_ff;
   assign rsp_winning_component = win_ff;
   assign rsp_score_difference  = sdiff_ff;
   assign rsp_frame_end         = lst_ff[NS-1];

endmodule
